### rtl/core/hcb_pkg.sv
`timescale 1ns / 1ps

package hcb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int WEIGHT_BITS = 24;

    localparam int SYM_W   = 8;
    localparam int WIN_MAX = 24;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 63;

    localparam int LIDX_W = $clog2(MAX_SYMBOLS);
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_W = $clog2(2 * MAX_SYMBOLS - 1);
    localparam int SUM_W  = WEIGHT_BITS + LIDX_W;
    localparam int WIN_W  = (WEIGHT_BITS < WIN_MAX) ? WEIGHT_BITS : WIN_MAX;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD_CHK,
        S_FETCH_A,
        S_PICK_A,
        S_FETCH_B,
        S_PICK_B,
        S_MERGE,
        S_WALK_ROOT,
        S_VISIT,
        S_ACT,
        S_EMIT,
        S_POP,
        S_RESTORE
    } t_state;

    typedef struct packed {
        logic load_en;
        logic build_init;
        logic pick_a;
        logic pick_b;
        logic merge_wr;
        logic walk_root;
        logic expand;
        logic emit_load;
        logic pop_rd;
        logic restore;
        logic run_clear;
    } t_cmd;

    typedef struct packed {
        logic merge_done;
        logic leaf_node;
        logic out_done;
        logic out_last;
    } t_stat;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CODE_W-1:0] path;
        logic [LEN_W-1:0]  depth;
    } t_stack_entry;

endpackage

### rtl/core/hcb_in_if.sv
`timescale 1ns / 1ps

interface hcb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  symbol;
    logic [23:0] weight;
    logic        last_symbol;

    modport source (output valid, symbol, weight, last_symbol, input ready);
    modport sink   (input valid, symbol, weight, last_symbol, output ready);
endinterface

### rtl/core/hcb_out_if.sv
`timescale 1ns / 1ps

interface hcb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  code_symbol;
    logic [5:0]  code_length;
    logic [62:0] code_bits;
    logic        last_code;
    logic        dropped;

    modport source (output valid, code_symbol, code_length, code_bits, last_code, dropped,
                    input ready);
    modport sink   (input valid, code_symbol, code_length, code_bits, last_code, dropped,
                    output ready);
endinterface

### rtl/core/hcb_ctrl.sv
`timescale 1ns / 1ps

module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load_en = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.build_init = 1'b1;
                    n_state          = S_BUILD_CHK;
                end
            end
            S_BUILD_CHK: begin
                n_state = i_stat.merge_done ? S_WALK_ROOT : S_FETCH_A;
            end
            S_FETCH_A: n_state = S_PICK_A;
            S_PICK_A: begin
                o_cmd.pick_a = 1'b1;
                n_state      = S_FETCH_B;
            end
            S_FETCH_B: n_state = S_PICK_B;
            S_PICK_B: begin
                o_cmd.pick_b = 1'b1;
                n_state      = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge_wr = 1'b1;
                n_state        = S_BUILD_CHK;
            end
            S_WALK_ROOT: begin
                o_cmd.walk_root = 1'b1;
                n_state         = S_VISIT;
            end
            S_VISIT: n_state = S_ACT;
            S_ACT: begin
                if (i_stat.leaf_node) begin
                    o_cmd.emit_load = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.expand = 1'b1;
                    n_state      = S_VISIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_done) begin
                    if (i_stat.out_last) begin
                        o_cmd.run_clear = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_RESTORE;
            end
            S_RESTORE: begin
                o_cmd.restore = 1'b1;
                n_state       = S_VISIT;
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

### rtl/core/hcb_dp.sv
`timescale 1ns / 1ps

module hcb_dp
    import hcb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [7:0]        i_symbol,
    input  logic [23:0]       i_weight,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [SYM_W-1:0]  o_code_symbol,
    output logic [LEN_W-1:0]  o_code_length,
    output logic [CODE_W-1:0] o_code_bits,
    output logic              o_last_code,
    output logic              o_dropped
);

    logic [SUM_W-1:0]  m_lw  [MAX_SYMBOLS];
    logic [SUM_W-1:0]  m_mw  [MAX_SYMBOLS];
    logic [SYM_W-1:0]  m_sym [MAX_SYMBOLS];
    logic [NODE_W-1:0] m_zc  [MAX_SYMBOLS];
    logic [NODE_W-1:0] m_oc  [MAX_SYMBOLS];
    t_stack_entry      m_stk [MAX_SYMBOLS];

    logic [CNT_W-1:0]  r_leaf_total;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_lh;
    logic [CNT_W-1:0]  r_mh;
    logic [CNT_W-1:0]  r_mt;
    logic [LIDX_W-1:0] r_sp;
    logic [SUM_W-1:0]  r_wa;
    logic [SUM_W-1:0]  r_wb;
    logic [NODE_W-1:0] r_ida;
    logic [NODE_W-1:0] r_idb;
    logic [NODE_W-1:0] r_node;
    logic [CODE_W-1:0] r_path;
    logic [LEN_W-1:0]  r_depth;
    logic              r_out_valid;

    logic [SUM_W-1:0]  r_lw_q;
    logic [SUM_W-1:0]  r_mw_q;
    logic [SYM_W-1:0]  r_sym_q;
    logic [NODE_W-1:0] r_zc_q;
    logic [NODE_W-1:0] r_oc_q;
    t_stack_entry      r_stk_q;

    logic              full;
    logic              leaf_ok;
    logic              merged_ok;
    logic              take_leaf;
    logic [SUM_W-1:0]  pick_w;
    logic [NODE_W-1:0] pick_id;
    logic [NODE_W-1:0] n_ext;
    logic [LIDX_W-1:0] k_idx;
    logic [LIDX_W-1:0] sp_m1;
    logic              out_done;

    assign full      = (r_leaf_total == CNT_W'(MAX_SYMBOLS));
    assign n_ext     = NODE_W'(r_leaf_total);
    assign leaf_ok   = (r_lh < r_leaf_total);
    assign merged_ok = (r_mh < r_mt);
    // ties go to the merged queue
    assign take_leaf = !merged_ok || (leaf_ok && (r_lw_q < r_mw_q));
    assign pick_w    = take_leaf ? r_lw_q : r_mw_q;
    assign pick_id   = take_leaf ? NODE_W'(r_lh) : NODE_W'(n_ext + NODE_W'(r_mh));
    assign k_idx     = LIDX_W'(r_node - n_ext);
    assign sp_m1     = r_sp - LIDX_W'(1);
    assign out_done  = r_out_valid && i_out_ready;

    always_comb begin
        o_stat = '0;
        o_stat.merge_done = (r_leaf_total < CNT_W'(2)) ||
                            ((r_mt + CNT_W'(1)) == r_leaf_total);
        o_stat.leaf_node  = (CNT_W'(r_node) < r_leaf_total);
        o_stat.out_done   = out_done;
        o_stat.out_last   = o_last_code;
    end

    // memory ports: registered reads every cycle
    always_ff @(posedge i_clk) begin
        r_lw_q  <= m_lw[r_lh[LIDX_W-1:0]];
        r_mw_q  <= m_mw[r_mh[LIDX_W-1:0]];
        r_sym_q <= m_sym[r_node[LIDX_W-1:0]];
        r_zc_q  <= m_zc[k_idx];
        r_oc_q  <= m_oc[k_idx];
        r_stk_q <= m_stk[sp_m1];
        if (i_cmd.load_en && !full) begin
            m_lw[r_leaf_total[LIDX_W-1:0]]  <= SUM_W'(i_weight[WIN_W-1:0]);
            m_sym[r_leaf_total[LIDX_W-1:0]] <= i_symbol;
        end
        if (i_cmd.merge_wr) begin
            m_mw[r_mt[LIDX_W-1:0]] <= r_wa + r_wb;
            m_zc[r_mt[LIDX_W-1:0]] <= r_ida;
            m_oc[r_mt[LIDX_W-1:0]] <= r_idb;
        end
        if (i_cmd.expand) begin
            m_stk[r_sp] <= '{node: r_oc_q, path: {r_path[CODE_W-2:0], 1'b1},
                             depth: r_depth + LEN_W'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_total <= '0;
            r_ovf        <= 1'b0;
            r_lh         <= '0;
            r_mh         <= '0;
            r_mt         <= '0;
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_en) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_leaf_total <= r_leaf_total + CNT_W'(1);
                end
            end
            if (i_cmd.build_init || i_cmd.run_clear) begin
                r_lh <= '0;
                r_mh <= '0;
                r_mt <= '0;
            end
            if (i_cmd.pick_a || i_cmd.pick_b) begin
                if (take_leaf) begin
                    if (leaf_ok) r_lh <= r_lh + CNT_W'(1);
                end else begin
                    r_mh <= r_mh + CNT_W'(1);
                end
            end
            if (i_cmd.merge_wr)  r_mt <= r_mt + CNT_W'(1);
            if (i_cmd.walk_root) r_sp <= '0;
            if (i_cmd.expand)    r_sp <= r_sp + LIDX_W'(1);
            if (i_cmd.pop_rd)    r_sp <= sp_m1;
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (out_done) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.run_clear) begin
                r_leaf_total <= '0;
                r_ovf        <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_a) begin
            r_wa  <= pick_w;
            r_ida <= pick_id;
        end
        if (i_cmd.pick_b) begin
            r_wb  <= pick_w;
            r_idb <= pick_id;
        end
        if (i_cmd.walk_root) begin
            r_node  <= (r_leaf_total >= CNT_W'(2)) ? NODE_W'((n_ext << 1) - NODE_W'(2))
                                                    : '0;
            r_path  <= '0;
            r_depth <= '0;
        end
        if (i_cmd.expand) begin
            r_node  <= r_zc_q;
            r_path  <= {r_path[CODE_W-2:0], 1'b0};
            r_depth <= r_depth + LEN_W'(1);
        end
        if (i_cmd.restore) begin
            r_node  <= r_stk_q.node;
            r_path  <= r_stk_q.path;
            r_depth <= r_stk_q.depth;
        end
        if (i_cmd.emit_load) begin
            o_code_symbol <= r_sym_q;
            o_code_length <= r_depth;
            o_code_bits   <= r_path;
            o_last_code   <= (r_sp == '0);
            o_dropped     <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done && o_last_code |=> (r_leaf_total == '0) && !r_ovf)
        else $error("run state not cleared after final code");

    a_pick_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pick_a || i_cmd.pick_b) |-> (leaf_ok || merged_ok))
        else $error("pick with both queues empty");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.expand |-> (r_sp < LIDX_W'(MAX_SYMBOLS - 1)))
        else $error("walk stack overflow");

    a_no_emit_over_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> !r_out_valid)
        else $error("result register overwritten");

endmodule

### rtl/core/huffman_code_builder_unit.sv
`timescale 1ns / 1ps

// Huffman code builder (two-queue merge).
// Input channel i_in carries symbol/weight requests; each is stored as a leaf
// in arrival order, one per cycle while i_in.ready is high. The request with
// last_symbol set closes the set; i_in.ready then drops until every code of
// that set has been delivered. Codes come out on o_out, one per leaf in
// left-first tree order, with last_code on the final one. Codes are optimal
// for ascending weights. Each merge (n-1 merges for n leaves) steps through a
// queue check, two fetch/compare picks through the registered weight memories
// and one write. The walk visits each internal node and each leaf, resumes
// from the stack after every leaf but the last, and waits while the receiver
// holds o_out.ready low.
// Sets larger than MAX_SYMBOLS drop the extra requests and flag dropped.
// Reset (synchronous, active low) empties the set and returns to loading.
// A stalled receiver holds the current code; the walk waits behind it.

module huffman_code_builder_unit
    import hcb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcb_in_if.sink    i_in,
    hcb_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_symbol),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    hcb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_symbol      (i_in.symbol),
        .i_weight      (i_in.weight),
        .i_out_ready   (o_out.ready),
        .o_stat        (stat),
        .o_out_valid   (o_out.valid),
        .o_code_symbol (o_out.code_symbol),
        .o_code_length (o_out.code_length),
        .o_code_bits   (o_out.code_bits),
        .o_last_code   (o_out.last_code),
        .o_dropped     (o_out.dropped)
    );

endmodule

### dv/huffman_code_builder_unit_tb.sv
`timescale 1ns / 1ps

module huffman_code_builder_unit_tb
    import hcb_pkg::*;
();

    typedef struct {
        logic [7:0]  symbol;
        logic [23:0] weight;
        logic        last_symbol;
    } t_leaf_req;

    typedef struct {
        logic [7:0]  code_symbol;
        logic [5:0]  code_length;
        logic [62:0] code_bits;
        logic        last_code;
        logic        dropped;
    } t_code;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hcb_in_if  in_ch ();
    hcb_out_if out_ch ();

    huffman_code_builder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    t_leaf_req pending_reqs[$];
    t_code     expected_codes[$];
    int        mismatch_count = 0;
    bit        stimulus_done = 1'b0;

    // code builder state
    logic [7:0]  set_symbols[MAX_SYMBOLS];
    logic [63:0] set_weights[2*MAX_SYMBOLS-1];
    int          zero_of[MAX_SYMBOLS];
    int          one_of[MAX_SYMBOLS];
    int          set_size = 0;
    bit          set_overflow = 1'b0;
    int          leaf_head, merged_head, merged_tail;

    function automatic int pick_smaller(int n);
        int lid, mid;
        lid = leaf_head;
        mid = n + merged_head;
        if (merged_head >= merged_tail ||
            (leaf_head < n && set_weights[lid] < set_weights[mid])) begin
            if (leaf_head < n) leaf_head++;
            return lid;
        end
        merged_head++;
        return mid;
    endfunction

    task automatic accept_leaf(t_leaf_req r);
        int n, a, b, k, node, count;
        int node_stk[$];
        logic [62:0] bits_stk[$];
        int depth_stk[$];
        logic [62:0] path;
        int depth;
        t_code c;
        t_code codes[$];
        if (set_size < MAX_SYMBOLS) begin
            set_symbols[set_size] = r.symbol;
            set_weights[set_size] = 64'(r.weight);
            set_size++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!r.last_symbol) return;
        n = set_size;
        leaf_head = 0; merged_head = 0; merged_tail = 0;
        while (n >= 2 && merged_tail < n - 1) begin
            a = pick_smaller(n);
            b = pick_smaller(n);
            k = merged_tail;
            zero_of[k] = a;
            one_of[k] = b;
            set_weights[n + k] = set_weights[a] + set_weights[b];
            merged_tail++;
        end
        node_stk.push_back(n >= 2 ? 2 * n - 2 : 0);
        bits_stk.push_back('0);
        depth_stk.push_back(0);
        count = 0;
        while (node_stk.size() > 0 && count < MAX_SYMBOLS) begin
            node = node_stk.pop_back();
            path = bits_stk.pop_back();
            depth = depth_stk.pop_back();
            if (node < n) begin
                c.code_symbol = set_symbols[node];
                c.code_length = 6'(depth);
                c.code_bits = path;
                c.last_code = 1'b0;
                c.dropped = set_overflow;
                codes.push_back(c);
                count++;
            end else if (depth < 63) begin
                k = node - n;
                node_stk.push_back(one_of[k]);
                bits_stk.push_back({path[61:0], 1'b1});
                depth_stk.push_back(depth + 1);
                node_stk.push_back(zero_of[k]);
                bits_stk.push_back({path[61:0], 1'b0});
                depth_stk.push_back(depth + 1);
            end
        end
        if (codes.size() > 0) codes[codes.size()-1].last_code = 1'b1;
        foreach (codes[i]) expected_codes.push_back(codes[i]);
        set_size = 0;
        set_overflow = 1'b0;
    endtask

    // random weight: mostly small, sometimes full range
    function automatic logic [23:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 3));
            default: return 24'($urandom_range(0, 1000));
        endcase
    endfunction

    task automatic queue_set(int size, bit ascending, bit wide);
        t_leaf_req r;
        logic [23:0] w;
        w = '0;
        for (int i = 0; i < size; i++) begin
            r.symbol = 8'($urandom);
            if (ascending) begin
                w = w + 24'($urandom_range(0, wide ? 200000 : 40));
                r.weight = w;
            end else begin
                r.weight = rand_weight();
            end
            r.last_symbol = (i == size - 1);
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        int total;
        t_leaf_req r;
        // lone symbol, full-range fields
        r = '{8'hFF, 24'hFFFFFF, 1'b1}; pending_reqs.push_back(r);
        r = '{8'h00, 24'h000000, 1'b1}; pending_reqs.push_back(r);
        // equal weights: ties go to the merged queue
        for (int i = 0; i < 4; i++) begin
            r = '{8'(8'hA0 + i), 24'd5, i == 3};
            pending_reqs.push_back(r);
        end
        // two leaves at the extremes
        r = '{8'h00, 24'hFFFFFF, 1'b0}; pending_reqs.push_back(r);
        r = '{8'hFF, 24'h000000, 1'b1}; pending_reqs.push_back(r);
        // descending weights
        for (int i = 0; i < 5; i++) begin
            r = '{8'(i), 24'(24'hFFFFFF >> (4 * i)), i == 4};
            pending_reqs.push_back(r);
        end
        // overflow: full set plus extra, final one dropped too
        queue_set(MAX_SYMBOLS, 1'b1, 1'b1);
        pending_reqs[pending_reqs.size()-1].last_symbol = 1'b0;
        r = '{8'h5A, 24'h123456, 1'b0}; pending_reqs.push_back(r);
        r = '{8'hA5, 24'h654321, 1'b1}; pending_reqs.push_back(r);
        // exactly full set, ascending weights with small steps
        queue_set(MAX_SYMBOLS, 1'b1, 1'b0);
        total = pending_reqs.size();
        while (total < 220) begin
            int sz;
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 10);
            queue_set(sz, $urandom_range(0, 3) != 0, $urandom_range(0, 1));
            total += sz;
        end
        stimulus_done = 1'b1;
    end

    // driver
    int  send_gap = 0;
    bit  in_busy = 1'b0;
    t_leaf_req in_cur;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.symbol = '0;
        in_ch.weight = '0;
        in_ch.last_symbol = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_busy && in_ch.valid && in_ch.ready) begin
                accept_leaf(in_cur);
                in_busy = 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            end
            if (!in_busy && send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (!in_busy && pending_reqs.size() > 0) begin
                in_cur = pending_reqs.pop_front();
                in_busy = 1'b1;
                in_ch.valid <= 1'b1;
                in_ch.symbol <= in_cur.symbol;
                in_ch.weight <= in_cur.weight;
                in_ch.last_symbol <= in_cur.last_symbol;
            end else if (!in_busy) begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        t_code exp_c;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_codes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected code: sym %0h len %0d bits %0h",
                                 out_ch.code_symbol, out_ch.code_length, out_ch.code_bits);
                end else begin
                    exp_c = expected_codes.pop_front();
                    if (out_ch.code_symbol !== exp_c.code_symbol ||
                        out_ch.code_length !== exp_c.code_length ||
                        out_ch.code_bits !== exp_c.code_bits ||
                        out_ch.last_code !== exp_c.last_code ||
                        out_ch.dropped !== exp_c.dropped) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("code mismatch: exp sym %0h len %0d bits %0h ",
                                     exp_c.code_symbol, exp_c.code_length, exp_c.code_bits,
                                     "last %0b drop %0b, ",
                                     exp_c.last_code, exp_c.dropped,
                                     "got sym %0h len %0d bits %0h ",
                                     out_ch.code_symbol, out_ch.code_length,
                                     out_ch.code_bits,
                                     "last %0b drop %0b",
                                     out_ch.last_code, out_ch.dropped);
                    end
                end
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && pending_reqs.size() == 0 && !in_busy &&
              expected_codes.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && expected_codes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
